// ----- rtl/core/rgb_hsv_color_converter_top_macros.svh -----
// ---------------------------------------------------------------------------
// RGB/HSV converter assertion macros
// Concurrent assertion wrappers shared by the converter RTL.
// ---------------------------------------------------------------------------
`ifndef RGB_HSV_COLOR_CONVERTER_TOP_MACROS_SVH
`define RGB_HSV_COLOR_CONVERTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define RHC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define RHC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RHC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define RHC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/core/rhc_pkg.sv -----
// ---------------------------------------------------------------------------
// RGB/HSV converter package
// Shared types, constants and the divide-by-255 helper.
// ---------------------------------------------------------------------------
package rhc_pkg;

  localparam int DIV_STEPS  = 9;
  localparam int HSV_STAGES = 3;
  localparam int HSV_PAD    = DIV_STEPS + 1 - HSV_STAGES;
  localparam int PIPE_DEPTH = DIV_STEPS + 2;

  localparam logic        ACT_RGB2HSV = 1'b0;
  localparam logic        ACT_HSV2RGB = 1'b1;

  localparam logic [10:0] HUE_ZERO  = 11'd0;
  localparam logic [10:0] HUE_GREEN = 11'd512;
  localparam logic [10:0] HUE_BLUE  = 11'd1024;
  localparam logic [10:0] HUE_FULL  = 11'd1536;
  localparam logic [15:0] HSV_K     = 16'd65280;

  typedef struct packed {
    logic [7:0] den;
    logic [7:0] rem;
    logic [8:0] low;
    logic [8:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic        action;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [10:0] hue;
    logic [7:0]  sat;
    logic [7:0]  val;
    logic [10:0] hue_base;
    logic        hue_neg;
    logic        hue_zero;
    logic        sat_zero;
  } side_t;

  typedef struct packed {
    div_lane_t sat_lane;
    div_lane_t hue_lane;
    side_t     side;
  } stage_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // floor(y/255) for y below 65280
  function automatic logic [7:0] div255(input logic [15:0] y);
    logic [16:0] sum;
    sum = {1'b0, y} + {9'h000, y[15:8]} + 17'd1;
    return sum[15:8];
  endfunction

endpackage

// ----- rtl/core/rgb_hsv_color_converter_top.sv -----
// ---------------------------------------------------------------------------
// RGB/HSV color converter
// Converts one color per request, RGB to HSV or HSV to RGB, fully pipelined.
// ---------------------------------------------------------------------------
//  channel   handshake          payload
//  in_       start, busy        in_action, in_red/green/blue, in_hue/sat/val
//  out_      out_valid strobe   out_red/green/blue, out_hue/sat/val
//
//  One request per cycle; each request passes the entry stage, the nine-step restoring
//  divider and the exit stage in that order before its result is shown on out_.
//  busy stays low: the pipeline never stalls and the receiver cannot hold it.
//  Reset clears only the valid bits; payload registers are not reset.
// ---------------------------------------------------------------------------
module rgb_hsv_color_converter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [10:0] in_hue,
  input  logic [7:0]  in_sat,
  input  logic [7:0]  in_val,
  output logic        out_valid,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [10:0] out_hue,
  output logic [7:0]  out_sat,
  output logic [7:0]  out_val
);
  import rhc_pkg::*;

  logic                 accept;
  logic [DIV_STEPS:0]   vld;
  stage_t               pipe [DIV_STEPS+1];
  rgb_t                 hsv_rgb;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  rhc_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (accept),
    .in_action (in_action),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .in_hue    (in_hue),
    .in_sat    (in_sat),
    .in_val    (in_val),
    .valid_o   (vld[0]),
    .stage_o   (pipe[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    rhc_div_stage u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (vld[i]),
      .stage_i (pipe[i]),
      .valid_o (vld[i+1]),
      .stage_o (pipe[i+1])
    );
  end

  rhc_hsv2rgb u_hsv2rgb (
    .clk   (clk),
    .hue   (in_hue),
    .sat   (in_sat),
    .val   (in_val),
    .rgb_o (hsv_rgb)
  );

  rhc_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (vld[DIV_STEPS]),
    .stage_i   (pipe[DIV_STEPS]),
    .hsv_rgb   (hsv_rgb),
    .out_valid (out_valid),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_hue   (out_hue),
    .out_sat   (out_sat),
    .out_val   (out_val)
  );

`include "rgb_hsv_color_converter_top_macros.svh"

  `RHC_ASSERT_SAME(a_request_yields_result, clk, rst_n,
    accept,
    ##PIPE_DEPTH out_valid,
    "request produced no result")
  `RHC_ASSERT_SAME(a_result_has_request, clk, rst_n,
    out_valid,
    $past(accept, PIPE_DEPTH),
    "result without matching request")

endmodule

// ----- rtl/core/rhc_prep.sv -----
// ---------------------------------------------------------------------------
// RGB/HSV converter front stage
// Finds max, min and delta, picks the hue sector and loads both divider lanes.
// ---------------------------------------------------------------------------
module rhc_prep (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            valid_i,
  input  logic            in_action,
  input  logic [7:0]      in_red,
  input  logic [7:0]      in_green,
  input  logic [7:0]      in_blue,
  input  logic [10:0]     in_hue,
  input  logic [7:0]      in_sat,
  input  logic [7:0]      in_val,
  output logic            valid_o,
  output rhc_pkg::stage_t stage_o
);
  import rhc_pkg::*;

  logic        valid_r;
  stage_t      stage_r;
  stage_t      stage_nxt;
  logic [7:0]  mx;
  logic [7:0]  mn;
  logic [7:0]  dlt;
  logic [7:0]  op_a;
  logic [7:0]  op_b;
  logic [7:0]  num;
  logic        neg;
  logic [10:0] base_pos;
  logic [10:0] base_neg;
  logic [15:0] sat_dvd;
  logic [15:0] hue_dvd;

  always_comb begin
    mx = in_red;
    if (in_green > mx) mx = in_green;
    if (in_blue > mx) mx = in_blue;
    mn = in_red;
    if (in_green < mn) mn = in_green;
    if (in_blue < mn) mn = in_blue;
    dlt = mx - mn;
    priority if (in_red == mx) begin
      op_a     = in_green;
      op_b     = in_blue;
      base_pos = HUE_ZERO;
      base_neg = HUE_FULL;
    end else if (in_green == mx) begin
      op_a     = in_blue;
      op_b     = in_red;
      base_pos = HUE_GREEN;
      base_neg = HUE_GREEN;
    end else begin
      op_a     = in_red;
      op_b     = in_green;
      base_pos = HUE_BLUE;
      base_neg = HUE_BLUE;
    end
    neg     = op_a < op_b;
    num     = neg ? (op_b - op_a) : (op_a - op_b);
    sat_dvd = {dlt, 8'h00} - {8'h00, dlt};
    hue_dvd = {num, 8'h00};

    stage_nxt.sat_lane.den = mx;
    stage_nxt.sat_lane.rem = {1'b0, sat_dvd[15:9]};
    stage_nxt.sat_lane.low = sat_dvd[8:0];
    stage_nxt.sat_lane.quo = 9'h000;
    stage_nxt.hue_lane.den = dlt;
    stage_nxt.hue_lane.rem = {1'b0, hue_dvd[15:9]};
    stage_nxt.hue_lane.low = hue_dvd[8:0];
    stage_nxt.hue_lane.quo = 9'h000;

    stage_nxt.side.action   = in_action;
    stage_nxt.side.red      = in_red;
    stage_nxt.side.green    = in_green;
    stage_nxt.side.blue     = in_blue;
    stage_nxt.side.hue      = in_hue;
    stage_nxt.side.sat      = in_sat;
    stage_nxt.side.val      = in_val;
    stage_nxt.side.hue_base = neg ? base_neg : base_pos;
    stage_nxt.side.hue_neg  = neg;
    stage_nxt.side.hue_zero = (dlt == 8'h00);
    stage_nxt.side.sat_zero = (mx == 8'h00);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
    stage_r <= stage_nxt;
  end

  assign valid_o = valid_r;
  assign stage_o = stage_r;

`include "rgb_hsv_color_converter_top_macros.svh"

  `RHC_ASSERT_SAME(a_hue_num_le_delta, clk, rst_n,
    valid_r && !stage_r.side.hue_zero,
    stage_r.hue_lane.rem < stage_r.hue_lane.den,
    "hue numerator exceeds delta")

endmodule

// ----- rtl/core/rhc_div_stage.sv -----
// ---------------------------------------------------------------------------
// RGB/HSV converter divider step
// One restoring-division bit for the saturation and hue lanes.
// ---------------------------------------------------------------------------
module rhc_div_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            valid_i,
  input  rhc_pkg::stage_t stage_i,
  output logic            valid_o,
  output rhc_pkg::stage_t stage_o
);
  import rhc_pkg::*;

  logic   valid_r;
  stage_t stage_r;
  stage_t stage_nxt;

  function automatic div_lane_t div_step(input div_lane_t lane);
    div_lane_t  res;
    logic [8:0] part;
    logic [8:0] diff;
    logic       ge;
    part     = {lane.rem, lane.low[8]};
    diff     = part - {1'b0, lane.den};
    ge       = part >= {1'b0, lane.den};
    res.den  = lane.den;
    res.rem  = ge ? diff[7:0] : part[7:0];
    res.low  = {lane.low[7:0], 1'b0};
    res.quo  = {lane.quo[7:0], ge};
    return res;
  endfunction

  always_comb begin
    stage_nxt          = stage_i;
    stage_nxt.sat_lane = div_step(stage_i.sat_lane);
    stage_nxt.hue_lane = div_step(stage_i.hue_lane);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
    stage_r <= stage_nxt;
  end

  assign valid_o = valid_r;
  assign stage_o = stage_r;

`include "rgb_hsv_color_converter_top_macros.svh"

  `RHC_ASSERT_SAME(a_sat_rem_bound, clk, rst_n,
    valid_r && (stage_r.side.action == ACT_RGB2HSV) && !stage_r.side.sat_zero,
    stage_r.sat_lane.rem < stage_r.sat_lane.den,
    "saturation remainder not below divisor")

endmodule

// ----- rtl/core/rhc_hsv2rgb.sv -----
// ---------------------------------------------------------------------------
// RGB/HSV converter six-sector lane
// Computes p, q, t from hue, saturation and value and aligns to the divider.
// ---------------------------------------------------------------------------
module rhc_hsv2rgb (
  input  logic          clk,
  input  logic [10:0]   hue,
  input  logic [7:0]    sat,
  input  logic [7:0]    val,
  output rhc_pkg::rgb_t rgb_o
);
  import rhc_pkg::*;

  localparam logic [2:0] SECT_1 = 3'd1;
  localparam logic [2:0] SECT_2 = 3'd2;
  localparam logic [2:0] SECT_3 = 3'd3;
  localparam logic [2:0] SECT_4 = 3'd4;
  localparam logic [2:0] SECT_5 = 3'd5;

  logic [7:0]  f;
  logic [16:0] st_full;
  logic [15:0] sf_r;
  logic [15:0] st_r;
  logic [7:0]  ns_r;
  logic [7:0]  v1_r;
  logic [2:0]  sec1_r;
  logic [23:0] yq_r;
  logic [23:0] yt_r;
  logic [15:0] yp_r;
  logic [7:0]  v2_r;
  logic [2:0]  sec2_r;
  logic [7:0]  p;
  logic [7:0]  q;
  logic [7:0]  t;
  rgb_t        rgb_nxt;
  rgb_t        rgb_r;
  rgb_t        pad_r [HSV_PAD];

  assign f       = hue[7:0];
  assign st_full = {9'h000, sat} * (17'd256 - {9'h000, f});

  always_comb begin
    p = div255(yp_r);
    q = div255(yq_r[23:8]);
    t = div255(yt_r[23:8]);
    unique case (sec2_r)
      SECT_1:  rgb_nxt = '{red: q,    green: v2_r, blue: p};
      SECT_2:  rgb_nxt = '{red: p,    green: v2_r, blue: t};
      SECT_3:  rgb_nxt = '{red: p,    green: q,    blue: v2_r};
      SECT_4:  rgb_nxt = '{red: t,    green: p,    blue: v2_r};
      SECT_5:  rgb_nxt = '{red: v2_r, green: p,    blue: q};
      default: rgb_nxt = '{red: v2_r, green: t,    blue: p};
    endcase
  end

  always_ff @(posedge clk) begin
    sf_r   <= {8'h00, sat} * {8'h00, f};
    st_r   <= st_full[15:0];
    ns_r   <= 8'hFF - sat;
    v1_r   <= val;
    sec1_r <= hue[10:8];
    yq_r   <= {16'h0000, v1_r} * {8'h00, HSV_K - sf_r};
    yt_r   <= {16'h0000, v1_r} * {8'h00, HSV_K - st_r};
    yp_r   <= {8'h00, v1_r} * {8'h00, ns_r};
    v2_r   <= v1_r;
    sec2_r <= sec1_r;
    rgb_r  <= rgb_nxt;
    pad_r[0] <= rgb_r;
    for (int i = 1; i < HSV_PAD; i++) begin
      pad_r[i] <= pad_r[i-1];
    end
  end

  assign rgb_o = pad_r[HSV_PAD-1];

endmodule

// ----- rtl/core/rhc_post.sv -----
// ---------------------------------------------------------------------------
// RGB/HSV converter output stage
// Forms the final hue and saturation and registers both color triples.
// ---------------------------------------------------------------------------
module rhc_post (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            valid_i,
  input  rhc_pkg::stage_t stage_i,
  input  rhc_pkg::rgb_t   hsv_rgb,
  output logic            out_valid,
  output logic [7:0]      out_red,
  output logic [7:0]      out_green,
  output logic [7:0]      out_blue,
  output logic [10:0]     out_hue,
  output logic [7:0]      out_sat,
  output logic [7:0]      out_val
);
  import rhc_pkg::*;

  logic        out_valid_r;
  logic [7:0]  red_r;
  logic [7:0]  green_r;
  logic [7:0]  blue_r;
  logic [10:0] hue_r;
  logic [7:0]  sat_r;
  logic [7:0]  val_r;
  logic [10:0] hue_q;
  logic [10:0] hue_calc;
  logic [7:0]  sat_calc;

  assign hue_q = {2'b00, stage_i.hue_lane.quo};

  always_comb begin
    priority if (stage_i.side.hue_zero) begin
      hue_calc = HUE_ZERO;
    end else if (stage_i.side.hue_neg) begin
      hue_calc = stage_i.side.hue_base - hue_q;
    end else begin
      hue_calc = stage_i.side.hue_base + hue_q;
    end
    sat_calc = stage_i.side.sat_zero ? 8'h00 : stage_i.sat_lane.quo[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= valid_i;
    end
    if (stage_i.side.action == ACT_RGB2HSV) begin
      red_r   <= stage_i.side.red;
      green_r <= stage_i.side.green;
      blue_r  <= stage_i.side.blue;
      hue_r   <= hue_calc;
      sat_r   <= sat_calc;
      val_r   <= stage_i.sat_lane.den;
    end else begin
      red_r   <= hsv_rgb.red;
      green_r <= hsv_rgb.green;
      blue_r  <= hsv_rgb.blue;
      hue_r   <= stage_i.side.hue;
      sat_r   <= stage_i.side.sat;
      val_r   <= stage_i.side.val;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;
  assign out_hue   = hue_r;
  assign out_sat   = sat_r;
  assign out_val   = val_r;

`include "rgb_hsv_color_converter_top_macros.svh"

  `RHC_ASSERT_NEXT(a_hue_in_range, clk, rst_n,
    valid_i && (stage_i.side.action == ACT_RGB2HSV),
    out_hue < HUE_FULL,
    "computed hue out of range")

endmodule
